@@ rtl/apwc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package apwc_pkg;

  // Elapsed-counter width default
  localparam int COUNT_WIDTH_DEF = 16;

  // Configuration register indexes
  localparam logic [2:0] REG_WDOG_LIMIT      = 3'd0;
  localparam logic [2:0] REG_BLINK_MS_CAR    = 3'd1;
  localparam logic [2:0] REG_BLINK_MS_REMOTE = 3'd2;
  localparam logic [2:0] REG_STEER_MIN       = 3'd3;
  localparam logic [2:0] REG_STEER_MAX       = 3'd4;
  localparam logic [2:0] REG_PULSE_TRIM      = 3'd5;
  localparam logic [2:0] REG_REMOTE_SPEED    = 3'd6;
  localparam logic [2:0] REG_REMOTE_STEER    = 3'd7;

  // Configuration reset values
  localparam logic [15:0] RST_WDOG_LIMIT      = 16'd300;
  localparam logic [15:0] RST_BLINK_MS_CAR    = 16'd500;
  localparam logic [15:0] RST_BLINK_MS_REMOTE = 16'd100;
  localparam logic [7:0]  RST_STEER_MIN       = 8'd50;
  localparam logic [7:0]  RST_STEER_MAX       = 8'd130;
  localparam logic [9:0]  RST_PULSE_TRIM      = 10'd190;
  localparam logic [7:0]  RST_REMOTE_SPEED    = 8'd90;
  localparam logic [7:0]  RST_REMOTE_STEER    = 8'd90;

  // Commanded speed / steer after reset
  localparam logic [7:0]  CMD_RESET = 8'd90;

  // Item kinds
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Byte hunter
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_0       = 8'h30;
  localparam logic [7:0] CHAR_9       = 8'h39;
  localparam logic [7:0] CHAR_UA      = 8'h41;
  localparam logic [7:0] CHAR_UF      = 8'h46;
  localparam logic [7:0] CHAR_LA      = 8'h61;
  localparam logic [3:0] HUNT_IDLE    = 4'd0;
  localparam logic [3:0] HUNT_FIRST   = 4'd1;
  localparam logic [3:0] HUNT_LAST    = 4'd10;

  // Speed pulse: floor(spd*50/9) = (spd * 50 * 14564) >> 17, exact for spd < 256
  localparam logic [19:0] SPEED_RECIP = 20'd728200;
  localparam int          SPEED_SHIFT = 17;
  localparam logic [11:0] PULSE_BASE  = 12'd1000;
  localparam logic [11:0] PULSE_MAX   = 12'd2000;

  typedef struct packed {
    logic [15:0] wdog_limit;
    logic [15:0] blink_ms_car;
    logic [15:0] blink_ms_remote;
    logic [7:0]  steer_min;
    logic [7:0]  steer_max;
    logic [9:0]  pulse_trim;
    logic [7:0]  remote_speed;
    logic [7:0]  remote_steer;
  } cfg_t;

  // Complete packet handed from the parser to the controller
  typedef struct packed {
    logic       valid;
    logic [7:0] light;
    logic [7:0] control;
    logic [7:0] speed;
    logic [7:0] front;
    logic [7:0] rear;
  } commit_t;

  typedef struct packed {
    logic        light_reverse;
    logic        light_head;
    logic        light_brake;
    logic        turn_left;
    logic        turn_right;
    logic        speed_by_car;
    logic        steer_by_car;
    logic [10:0] speed_pulse_us;
    logic [7:0]  steer_front_deg;
    logic [7:0]  steer_rear_deg;
    logic        beacon;
  } result_t;

  // Hex character to value; anything not a digit or upper A..F decodes as lower case
  function automatic logic [7:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    if (b >= CHAR_0 && b <= CHAR_9) begin
      v = b - CHAR_0;
    end else if (b >= CHAR_UA && b <= CHAR_UF) begin
      v = b - CHAR_UA + 8'd10;
    end else begin
      v = b - CHAR_LA + 8'd10;
    end
    return v;
  endfunction

  // When the bounds cross, values below the low bound give it; all others give the high bound
  function automatic logic [7:0] clamp_steer(input logic [7:0] v, input logic [7:0] lo,
                                             input logic [7:0] hi);
    logic [7:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/apwc_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module apwc_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             byte_en,
  input  wire logic [7:0]       rx_byte,
  input  wire logic [7:0]       steer_min,
  input  wire logic [7:0]       steer_max,
  output apwc_pkg::commit_t     commit
);

  logic [3:0] hunt_r, hunt_nxt;
  logic [7:0] hi_r, hi_nxt;
  logic [7:0] staged_r [4];

  logic       hunting;
  logic [3:0] slot;
  logic [7:0] nib;
  logic [7:0] val;
  logic       stage_we;

  // Decode of the current character
  always_comb begin
    hunting  = (hunt_r == apwc_pkg::HUNT_IDLE) || (hunt_r > apwc_pkg::HUNT_LAST);
    slot     = hunt_r - apwc_pkg::HUNT_FIRST;
    nib      = apwc_pkg::hex_value(rx_byte);
    val      = {hi_r[3:0], 4'b0000} | nib;
    stage_we = byte_en && !hunting && slot[0] && (hunt_r != apwc_pkg::HUNT_LAST);
  end

  // Hunter sequencing and packet commit
  always_comb begin
    hunt_nxt = hunt_r;
    hi_nxt   = hi_r;
    commit   = '0;
    if (byte_en) begin
      if (hunting) begin
        hunt_nxt = (rx_byte == apwc_pkg::CHAR_NEWLINE) ? apwc_pkg::HUNT_FIRST
                                                       : apwc_pkg::HUNT_IDLE;
      end else if (!slot[0]) begin
        hi_nxt   = nib;
        hunt_nxt = hunt_r + 4'd1;
      end else if (hunt_r != apwc_pkg::HUNT_LAST) begin
        hunt_nxt = hunt_r + 4'd1;
      end else begin
        commit.valid   = 1'b1;
        commit.light   = staged_r[0];
        commit.control = staged_r[1];
        commit.speed   = staged_r[2];
        commit.front   = apwc_pkg::clamp_steer(staged_r[3], steer_min, steer_max);
        commit.rear    = apwc_pkg::clamp_steer(val, steer_min, steer_max);
        hunt_nxt       = apwc_pkg::HUNT_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunt_r <= apwc_pkg::HUNT_IDLE;
      hi_r   <= '0;
    end else begin
      hunt_r <= hunt_nxt;
      hi_r   <= hi_nxt;
    end
  end

  // Staged packet bytes, no reset
  always_ff @(posedge clk) begin
    if (stage_we) begin
      staged_r[slot[2:1]] <= val;
    end
  end

endmodule

`default_nettype wire

@@ rtl/apwc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module apwc_ctrl #(
  parameter int COUNT_WIDTH = apwc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire logic              tick,
  input  wire apwc_pkg::commit_t commit,
  input  wire apwc_pkg::cfg_t    cfg,
  output apwc_pkg::result_t      res
);

  localparam int CW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  logic [7:0]             light_r, light_nxt;
  logic [7:0]             control_r, control_nxt;
  logic [7:0]             speed_r, speed_nxt;
  logic [7:0]             front_r, front_nxt;
  logic [7:0]             rear_r, rear_nxt;
  logic [COUNT_WIDTH-1:0] wd_r, wd_nxt;
  logic [COUNT_WIDTH-1:0] bl_r, bl_nxt;
  logic                   phase_r, phase_nxt;
  logic [1:0]             turn_r, turn_nxt;
  logic                   beacon_nxt;

  logic [15:0]            half;
  logic [7:0]             spd;
  logic [27:0]            prod;
  logic [11:0]            base_sum;
  logic [11:0]            offset;
  logic [11:0]            diff;
  logic [10:0]            pulse;

  // State update for one item
  always_comb begin
    light_nxt   = light_r;
    control_nxt = control_r;
    speed_nxt   = speed_r;
    front_nxt   = front_r;
    rear_nxt    = rear_r;
    wd_nxt      = wd_r;
    bl_nxt      = bl_r;
    phase_nxt   = phase_r;
    turn_nxt    = turn_r;
    beacon_nxt  = 1'b0;
    half        = '0;
    if (fire) begin
      // packet commit or millisecond tick
      if (commit.valid) begin
        light_nxt   = commit.light;
        control_nxt = commit.control;
        speed_nxt   = commit.speed;
        front_nxt   = commit.front;
        rear_nxt    = commit.rear;
        wd_nxt      = '0;
      end
      if (tick) begin
        if (wd_r != '1) wd_nxt = wd_r + 1'b1;
        if (bl_r != '1) bl_nxt = bl_r + 1'b1;
      end
      // watchdog fallback
      if (CW'(wd_nxt) > CW'(cfg.wdog_limit)) begin
        control_nxt = '0;
      end
      // blink timer
      half = (control_nxt != '0) ? cfg.blink_ms_car : cfg.blink_ms_remote;
      if (CW'(bl_nxt) > CW'(half)) begin
        bl_nxt     = '0;
        phase_nxt  = !phase_r;
        beacon_nxt = 1'b1;
        if (control_nxt != '0) begin
          turn_nxt = {phase_nxt & light_nxt[1], phase_nxt & light_nxt[0]};
        end else begin
          turn_nxt = {phase_nxt, phase_nxt};
        end
      end
    end
  end

  // Speed pulse from the updated state
  always_comb begin
    spd      = control_nxt[1] ? speed_nxt : cfg.remote_speed;
    prod     = spd * apwc_pkg::SPEED_RECIP;
    base_sum = {1'b0, prod[apwc_pkg::SPEED_SHIFT +: 11]} + apwc_pkg::PULSE_BASE;
    offset   = {2'b00, cfg.pulse_trim};
    diff     = base_sum - offset;
    if (base_sum < offset) begin
      pulse = '0;
    end else if (diff > apwc_pkg::PULSE_MAX) begin
      pulse = apwc_pkg::PULSE_MAX[10:0];
    end else begin
      pulse = diff[10:0];
    end
  end

  // Result fields
  always_comb begin
    res.light_reverse   = light_nxt[4];
    res.light_head      = light_nxt[3];
    res.light_brake     = light_nxt[2];
    res.turn_left       = turn_nxt[1];
    res.turn_right      = turn_nxt[0];
    res.speed_by_car    = control_nxt[1];
    res.steer_by_car    = control_nxt[0];
    res.speed_pulse_us  = pulse;
    res.steer_front_deg = control_nxt[0] ? front_nxt : cfg.remote_steer;
    res.steer_rear_deg  = control_nxt[0] ? rear_nxt : cfg.remote_steer;
    res.beacon          = beacon_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r   <= '0;
      control_r <= '0;
      speed_r   <= apwc_pkg::CMD_RESET;
      front_r   <= apwc_pkg::CMD_RESET;
      rear_r    <= apwc_pkg::CMD_RESET;
      wd_r      <= '0;
      bl_r      <= '0;
      phase_r   <= 1'b0;
      turn_r    <= '0;
    end else begin
      light_r   <= light_nxt;
      control_r <= control_nxt;
      speed_r   <= speed_nxt;
      front_r   <= front_nxt;
      rear_r    <= rear_nxt;
      wd_r      <= wd_nxt;
      bl_r      <= bl_nxt;
      phase_r   <= phase_nxt;
      turn_r    <= turn_nxt;
    end
  end

  // A committed packet restarts the watchdog
  a_commit_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    fire && commit.valid |=> wd_r == '0)
    else $error("watchdog not restarted by packet");

  // A beacon restarts the blink timer and flips the phase
  a_beacon_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && beacon_nxt |=> bl_r == '0 && phase_r != $past(phase_r))
    else $error("blink timer not restarted on beacon");

  // Control state moves only on an item
  a_control_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(control_r) && $stable(phase_r))
    else $error("control state changed without an item");

endmodule

`default_nettype wire

@@ rtl/actuator_packet_watchdog_controller_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Actuator packet and watchdog controller. Requests are either a received
// serial byte or a one-millisecond tick; each request yields exactly one result
// with the light, steering and speed outputs after that request. The block
// takes one request per clock as long as out_stall is low: a request sits in
// an input register while the hunter, watchdog, blink timer and speed-pulse
// multiply are evaluated, and its result then lands in a result register. A
// stall on the result side holds the input register, which then raises
// in_stall. Configuration writes take effect at the next edge; write them while
// no request is in flight.
module actuator_packet_watchdog_controller_top #(
  parameter int COUNT_WIDTH = apwc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_light_reverse,
  output logic             out_light_head,
  output logic             out_light_brake,
  output logic             out_turn_left,
  output logic             out_turn_right,
  output logic             out_speed_by_car,
  output logic             out_steer_by_car,
  output logic [10:0]      out_speed_pulse_us,
  output logic [7:0]       out_steer_front_deg,
  output logic [7:0]       out_steer_rear_deg,
  output logic             out_beacon,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  apwc_pkg::cfg_t    cfg_r;
  logic              in_valid_r;
  logic              in_cmd_r;
  logic [7:0]        in_byte_r;
  logic              out_valid_r;
  apwc_pkg::result_t out_data_r;

  logic              advance;
  logic              fire;
  logic              byte_en;
  logic              tick;
  apwc_pkg::commit_t commit;
  apwc_pkg::result_t res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wdog_limit      <= apwc_pkg::RST_WDOG_LIMIT;
      cfg_r.blink_ms_car    <= apwc_pkg::RST_BLINK_MS_CAR;
      cfg_r.blink_ms_remote <= apwc_pkg::RST_BLINK_MS_REMOTE;
      cfg_r.steer_min       <= apwc_pkg::RST_STEER_MIN;
      cfg_r.steer_max       <= apwc_pkg::RST_STEER_MAX;
      cfg_r.pulse_trim      <= apwc_pkg::RST_PULSE_TRIM;
      cfg_r.remote_speed    <= apwc_pkg::RST_REMOTE_SPEED;
      cfg_r.remote_steer    <= apwc_pkg::RST_REMOTE_STEER;
    end else if (cfg_we) begin
      case (cfg_index)
        apwc_pkg::REG_WDOG_LIMIT:      cfg_r.wdog_limit      <= cfg_wdata;
        apwc_pkg::REG_BLINK_MS_CAR:    cfg_r.blink_ms_car    <= cfg_wdata;
        apwc_pkg::REG_BLINK_MS_REMOTE: cfg_r.blink_ms_remote <= cfg_wdata;
        apwc_pkg::REG_STEER_MIN:       cfg_r.steer_min       <= cfg_wdata[7:0];
        apwc_pkg::REG_STEER_MAX:       cfg_r.steer_max       <= cfg_wdata[7:0];
        apwc_pkg::REG_PULSE_TRIM:      cfg_r.pulse_trim      <= cfg_wdata[9:0];
        apwc_pkg::REG_REMOTE_SPEED:    cfg_r.remote_speed    <= cfg_wdata[7:0];
        apwc_pkg::REG_REMOTE_STEER:    cfg_r.remote_steer    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign byte_en  = fire && (in_cmd_r == apwc_pkg::CMD_BYTE);
  assign tick     = fire && (in_cmd_r == apwc_pkg::CMD_TICK);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_cmd_r  <= in_command;
      in_byte_r <= in_rx_byte;
    end
  end

  apwc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (byte_en),
    .rx_byte   (in_byte_r),
    .steer_min (cfg_r.steer_min),
    .steer_max (cfg_r.steer_max),
    .commit    (commit)
  );

  apwc_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .tick   (tick),
    .commit (commit),
    .cfg    (cfg_r),
    .res    (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_light_reverse   = out_data_r.light_reverse;
  assign out_light_head      = out_data_r.light_head;
  assign out_light_brake     = out_data_r.light_brake;
  assign out_turn_left       = out_data_r.turn_left;
  assign out_turn_right      = out_data_r.turn_right;
  assign out_speed_by_car    = out_data_r.speed_by_car;
  assign out_steer_by_car    = out_data_r.steer_by_car;
  assign out_speed_pulse_us  = out_data_r.speed_pulse_us;
  assign out_steer_front_deg = out_data_r.steer_front_deg;
  assign out_steer_rear_deg  = out_data_r.steer_rear_deg;
  assign out_beacon          = out_data_r.beacon;

  // A processed request always lands in the result register
  a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed request lost");

  // A held request is not dropped while the result side stalls
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_valid_r && $stable(in_cmd_r) && $stable(in_byte_r))
    else $error("held request changed");

endmodule

`default_nettype wire

@@ sim/tb_actuator_packet_watchdog_controller_top.sv @@
`timescale 1ns / 1ps

module tb_actuator_packet_watchdog_controller_top;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_PRINTS  = 40;
  localparam logic [apwc_pkg::COUNT_WIDTH_DEF-1:0] COUNT_TOP = '1;

  // Outputs right after reset, and right after the first directed packet
  localparam apwc_pkg::result_t RES_RESET = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                              11'd1310, 8'd90, 8'd90, 1'b0};
  localparam apwc_pkg::result_t RES_FULL  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
                                              11'd2000, 8'd50, 8'd130, 1'b0};
  localparam apwc_pkg::result_t RES_NONE  = '0;

  typedef struct {
    logic              cmd;
    logic [7:0]        ch;
    bit                typed;
    apwc_pkg::result_t want;
  } plan_row_t;

  localparam int PLAN_LEN = 25;

  // Directed requests: reset outputs, a clamped full-scale packet, a tick with a
  // junk byte, a packet mixing newlines and non-hex with hex characters, then a tick.
  plan_row_t plan [PLAN_LEN] = '{
    '{apwc_pkg::CMD_BYTE, 8'h5A, 1'b1, RES_RESET},     // 'Z' while hunting
    '{apwc_pkg::CMD_BYTE, apwc_pkg::CHAR_NEWLINE, 1'b1, RES_RESET},
    '{apwc_pkg::CMD_BYTE, 8'h31, 1'b0, RES_NONE},      // "1F" light mask
    '{apwc_pkg::CMD_BYTE, 8'h46, 1'b0, RES_NONE},
    '{apwc_pkg::CMD_BYTE, 8'h30, 1'b0, RES_NONE},      // "03" control mask
    '{apwc_pkg::CMD_BYTE, 8'h33, 1'b0, RES_NONE},
    '{apwc_pkg::CMD_BYTE, 8'h66, 1'b0, RES_NONE},      // "ff" speed, lower case
    '{apwc_pkg::CMD_BYTE, 8'h66, 1'b0, RES_NONE},
    '{apwc_pkg::CMD_BYTE, 8'h30, 1'b0, RES_NONE},      // "00" front, clamps up
    '{apwc_pkg::CMD_BYTE, 8'h30, 1'b0, RES_NONE},
    '{apwc_pkg::CMD_BYTE, 8'h46, 1'b0, RES_NONE},      // "FF" rear, clamps down
    '{apwc_pkg::CMD_BYTE, 8'h46, 1'b1, RES_FULL},
    '{apwc_pkg::CMD_TICK, 8'hFF, 1'b0, RES_NONE},
    '{apwc_pkg::CMD_BYTE, apwc_pkg::CHAR_NEWLINE, 1'b0, RES_NONE},
    '{apwc_pkg::CMD_BYTE, apwc_pkg::CHAR_NEWLINE, 1'b0, RES_NONE}, // newline taken as data
    '{apwc_pkg::CMD_BYTE, apwc_pkg::CHAR_NEWLINE, 1'b0, RES_NONE},
    '{apwc_pkg::CMD_BYTE, 8'h47, 1'b0, RES_NONE},      // 'G'
    '{apwc_pkg::CMD_BYTE, 8'h00, 1'b0, RES_NONE},
    '{apwc_pkg::CMD_BYTE, 8'h61, 1'b0, RES_NONE},      // 'a'
    '{apwc_pkg::CMD_BYTE, 8'h39, 1'b0, RES_NONE},      // '9'
    '{apwc_pkg::CMD_BYTE, 8'h41, 1'b0, RES_NONE},      // 'A'
    '{apwc_pkg::CMD_BYTE, 8'hFF, 1'b0, RES_NONE},
    '{apwc_pkg::CMD_BYTE, 8'h30, 1'b0, RES_NONE},
    '{apwc_pkg::CMD_BYTE, 8'h80, 1'b0, RES_NONE},      // commits the packet
    '{apwc_pkg::CMD_TICK, 8'h00, 1'b0, RES_NONE}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_light_reverse;
  logic        out_light_head;
  logic        out_light_brake;
  logic        out_turn_left;
  logic        out_turn_right;
  logic        out_speed_by_car;
  logic        out_steer_by_car;
  logic [10:0] out_speed_pulse_us;
  logic [7:0]  out_steer_front_deg;
  logic [7:0]  out_steer_rear_deg;
  logic        out_beacon;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  // Shared control between the sender, receiver and monitor
  bit                calm;
  int                hold_req;
  bit                given_typed;
  apwc_pkg::result_t given_want;
  int                mismatch_count = 0;
  int                quiet_cycles = 0;
  apwc_pkg::result_t expected_outputs [$];

  // Controller model state
  apwc_pkg::cfg_t                       settings;
  logic [3:0]                           hunt_pos;
  logic [7:0]                           hi_nib;
  logic [7:0]                           staged [4];
  logic [7:0]                           light_mask;
  logic [7:0]                           ctrl_mask;
  logic [7:0]                           speed_cmd;
  logic [7:0]                           front_cmd;
  logic [7:0]                           rear_cmd;
  logic [apwc_pkg::COUNT_WIDTH_DEF-1:0] wd_elapsed;
  logic [apwc_pkg::COUNT_WIDTH_DEF-1:0] blink_elapsed;
  logic                                 blink_phase;
  logic [1:0]                           turn_lamps;

  actuator_packet_watchdog_controller_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_light_reverse   (out_light_reverse),
    .out_light_head      (out_light_head),
    .out_light_brake     (out_light_brake),
    .out_turn_left       (out_turn_left),
    .out_turn_right      (out_turn_right),
    .out_speed_by_car    (out_speed_by_car),
    .out_steer_by_car    (out_steer_by_car),
    .out_speed_pulse_us  (out_speed_pulse_us),
    .out_steer_front_deg (out_steer_front_deg),
    .out_steer_rear_deg  (out_steer_rear_deg),
    .out_beacon          (out_beacon),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic void reset_model();
    settings.wdog_limit      = apwc_pkg::RST_WDOG_LIMIT;
    settings.blink_ms_car    = apwc_pkg::RST_BLINK_MS_CAR;
    settings.blink_ms_remote = apwc_pkg::RST_BLINK_MS_REMOTE;
    settings.steer_min       = apwc_pkg::RST_STEER_MIN;
    settings.steer_max       = apwc_pkg::RST_STEER_MAX;
    settings.pulse_trim      = apwc_pkg::RST_PULSE_TRIM;
    settings.remote_speed    = apwc_pkg::RST_REMOTE_SPEED;
    settings.remote_steer    = apwc_pkg::RST_REMOTE_STEER;
    hunt_pos      = apwc_pkg::HUNT_IDLE;
    hi_nib        = '0;
    staged        = '{default: '0};
    light_mask    = '0;
    ctrl_mask     = '0;
    speed_cmd     = apwc_pkg::CMD_RESET;
    front_cmd     = apwc_pkg::CMD_RESET;
    rear_cmd      = apwc_pkg::CMD_RESET;
    wd_elapsed    = '0;
    blink_elapsed = '0;
    blink_phase   = 1'b0;
    turn_lamps    = '0;
  endfunction

  // Register write as seen on the configuration port
  function automatic void model_config(input logic [2:0] idx, input logic [15:0] val);
    case (idx)
      apwc_pkg::REG_WDOG_LIMIT:      settings.wdog_limit      = val;
      apwc_pkg::REG_BLINK_MS_CAR:    settings.blink_ms_car    = val;
      apwc_pkg::REG_BLINK_MS_REMOTE: settings.blink_ms_remote = val;
      apwc_pkg::REG_STEER_MIN:       settings.steer_min       = val[7:0];
      apwc_pkg::REG_STEER_MAX:       settings.steer_max       = val[7:0];
      apwc_pkg::REG_PULSE_TRIM:      settings.pulse_trim      = val[9:0];
      apwc_pkg::REG_REMOTE_SPEED:    settings.remote_speed    = val[7:0];
      apwc_pkg::REG_REMOTE_STEER:    settings.remote_steer    = val[7:0];
      default: ;
    endcase
  endfunction

  // Digits and upper A..F decode as hex; everything else as if lower case
  function automatic logic [7:0] nibble_of(input logic [7:0] ch);
    if (ch >= apwc_pkg::CHAR_0 && ch <= apwc_pkg::CHAR_9) begin
      return ch - apwc_pkg::CHAR_0;
    end
    if (ch >= apwc_pkg::CHAR_UA && ch <= apwc_pkg::CHAR_UF) begin
      return ch - apwc_pkg::CHAR_UA + 8'd10;
    end
    return ch - apwc_pkg::CHAR_LA + 8'd10;
  endfunction

  // When the bounds cross, values below the lower bound give it; all others the upper bound
  function automatic logic [7:0] bound_angle(input logic [7:0] v);
    if (v < settings.steer_min) return settings.steer_min;
    if (v > settings.steer_max) return settings.steer_max;
    return v;
  endfunction

  function automatic void feed_char(input logic [7:0] ch);
    logic [3:0] slot;
    logic [7:0] val;
    if (hunt_pos == apwc_pkg::HUNT_IDLE || hunt_pos > apwc_pkg::HUNT_LAST) begin
      hunt_pos = (ch == apwc_pkg::CHAR_NEWLINE) ? apwc_pkg::HUNT_FIRST : apwc_pkg::HUNT_IDLE;
      return;
    end
    slot = hunt_pos - apwc_pkg::HUNT_FIRST;
    if (!slot[0]) begin
      hi_nib = nibble_of(ch);
      hunt_pos = hunt_pos + 4'd1;
      return;
    end
    val = {hi_nib[3:0], 4'h0} | nibble_of(ch);
    if (slot[3:1] < 3'd4) begin
      staged[slot[2:1]] = val;
      hunt_pos = hunt_pos + 4'd1;
      return;
    end
    // Last character: the whole packet lands at once
    light_mask = staged[0];
    ctrl_mask  = staged[1];
    speed_cmd  = staged[2];
    front_cmd  = bound_angle(staged[3]);
    rear_cmd   = bound_angle(val);
    wd_elapsed = '0;
    hunt_pos   = apwc_pkg::HUNT_IDLE;
  endfunction

  function automatic apwc_pkg::result_t advance_controller(input logic cmd,
                                                           input logic [7:0] ch);
    apwc_pkg::result_t r;
    logic [15:0]       half;
    int                spd;
    int                pulse;
    r = '0;
    if (cmd == apwc_pkg::CMD_BYTE) begin
      feed_char(ch);
    end else begin
      if (wd_elapsed != COUNT_TOP) wd_elapsed = wd_elapsed + 1'b1;
      if (blink_elapsed != COUNT_TOP) blink_elapsed = blink_elapsed + 1'b1;
    end

    // Watchdog, then blink timer
    if (wd_elapsed > settings.wdog_limit) ctrl_mask = '0;
    half = (ctrl_mask != 0) ? settings.blink_ms_car : settings.blink_ms_remote;
    if (blink_elapsed > half) begin
      blink_elapsed = '0;
      blink_phase   = ~blink_phase;
      r.beacon      = 1'b1;
      if (ctrl_mask != 0) begin
        turn_lamps = {blink_phase & light_mask[1], blink_phase & light_mask[0]};
      end else begin
        turn_lamps = {2{blink_phase}};
      end
    end

    spd   = ctrl_mask[1] ? int'(speed_cmd) : int'(settings.remote_speed);
    pulse = spd * 1000 / 180 + 1000 - int'(settings.pulse_trim);
    if (pulse > 2000) pulse = 2000;
    if (pulse < 0) pulse = 0;

    r.light_reverse   = light_mask[4];
    r.light_head      = light_mask[3];
    r.light_brake     = light_mask[2];
    r.turn_left       = turn_lamps[1];
    r.turn_right      = turn_lamps[0];
    r.speed_by_car    = ctrl_mask[1];
    r.steer_by_car    = ctrl_mask[0];
    r.speed_pulse_us  = pulse[10:0];
    r.steer_front_deg = ctrl_mask[0] ? front_cmd : settings.remote_steer;
    r.steer_rear_deg  = ctrl_mask[0] ? rear_cmd : settings.remote_steer;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  task automatic compare_outputs(input apwc_pkg::result_t seen,
                                 input apwc_pkg::result_t want);
    if (seen.light_reverse !== want.light_reverse)
      report_mismatch("light_reverse", 16'(seen.light_reverse), 16'(want.light_reverse));
    if (seen.light_head !== want.light_head)
      report_mismatch("light_head", 16'(seen.light_head), 16'(want.light_head));
    if (seen.light_brake !== want.light_brake)
      report_mismatch("light_brake", 16'(seen.light_brake), 16'(want.light_brake));
    if (seen.turn_left !== want.turn_left)
      report_mismatch("turn_left", 16'(seen.turn_left), 16'(want.turn_left));
    if (seen.turn_right !== want.turn_right)
      report_mismatch("turn_right", 16'(seen.turn_right), 16'(want.turn_right));
    if (seen.speed_by_car !== want.speed_by_car)
      report_mismatch("speed_by_car", 16'(seen.speed_by_car), 16'(want.speed_by_car));
    if (seen.steer_by_car !== want.steer_by_car)
      report_mismatch("steer_by_car", 16'(seen.steer_by_car), 16'(want.steer_by_car));
    if (seen.speed_pulse_us !== want.speed_pulse_us)
      report_mismatch("speed_pulse_us", 16'(seen.speed_pulse_us),
                      16'(want.speed_pulse_us));
    if (seen.steer_front_deg !== want.steer_front_deg)
      report_mismatch("steer_front_deg", 16'(seen.steer_front_deg),
                      16'(want.steer_front_deg));
    if (seen.steer_rear_deg !== want.steer_rear_deg)
      report_mismatch("steer_rear_deg", 16'(seen.steer_rear_deg),
                      16'(want.steer_rear_deg));
    if (seen.beacon !== want.beacon)
      report_mismatch("beacon", 16'(seen.beacon), 16'(want.beacon));
  endtask

  // Monitor: results are checked before the same-edge request is queued
  always @(posedge clk) begin
    apwc_pkg::result_t seen;
    apwc_pkg::result_t want;
    if (!rst_n) begin
      reset_model();
    end else begin
      quiet_cycles++;
      if (cfg_we) begin
        model_config(cfg_index, cfg_wdata);
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        seen = '{out_light_reverse, out_light_head, out_light_brake, out_turn_left,
                 out_turn_right, out_speed_by_car, out_steer_by_car, out_speed_pulse_us,
                 out_steer_front_deg, out_steer_rear_deg, out_beacon};
        if (expected_outputs.size() == 0) begin
          report_mismatch("results outstanding", 16'd1, 16'd0);
        end else begin
          want = expected_outputs.pop_front();
          compare_outputs(seen, want);
        end
      end
      if (in_valid && !in_stall) begin
        quiet_cycles = 0;
        want = advance_controller(in_command, in_rx_byte);
        if (given_typed) want = given_want;
        expected_outputs.push_back(want);
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  initial begin
    int hold_left;
    int holds_taken;
    hold_left   = 0;
    holds_taken = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != holds_taken) begin
        holds_taken = hold_req;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 24);
      end
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic send_request(input logic cmd, input logic [7:0] ch,
                              input bit typed = 1'b0,
                              input apwc_pkg::result_t want = '0);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_rx_byte  <= ch;
    given_typed = typed;
    given_want  = want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_tick();
    send_request(apwc_pkg::CMD_TICK, 8'($urandom_range(255)));
  endtask

  function automatic logic [7:0] pick_hex_char();
    case ($urandom_range(2))
      0:       return apwc_pkg::CHAR_0 + 8'($urandom_range(9));
      1:       return apwc_pkg::CHAR_UA + 8'($urandom_range(5));
      default: return apwc_pkg::CHAR_LA + 8'($urandom_range(5));
    endcase
  endfunction

  // Mostly well-formed packets with ticks mixed in, plus tick bursts, truncated packets and noise
  task automatic run_traffic(input int n_items, input int burst_max);
    int sent;
    int k;
    int t;
    int r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 60) begin
        send_request(apwc_pkg::CMD_BYTE, apwc_pkg::CHAR_NEWLINE);
        sent++;
        for (k = 0; k < 10; k++) begin
          if ($urandom_range(99) < 15) begin
            for (t = $urandom_range(1, 3); t > 0; t--) begin
              send_tick();
              sent++;
            end
          end
          if ($urandom_range(99) < 8) begin
            send_request(apwc_pkg::CMD_BYTE, 8'($urandom_range(255)));
          end else begin
            send_request(apwc_pkg::CMD_BYTE, pick_hex_char());
          end
          sent++;
        end
      end else if (r < 85) begin
        for (t = $urandom_range(1, burst_max); t > 0; t--) begin
          send_tick();
          sent++;
        end
      end else if (r < 93) begin
        // truncated packet
        send_request(apwc_pkg::CMD_BYTE, apwc_pkg::CHAR_NEWLINE);
        sent++;
        for (t = $urandom_range(1, 9); t > 0; t--) begin
          send_request(apwc_pkg::CMD_BYTE, pick_hex_char());
          sent++;
        end
      end else begin
        for (t = $urandom_range(1, 12); t > 0; t--) begin
          send_request(apwc_pkg::CMD_BYTE, 8'($urandom_range(255)));
          sent++;
        end
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  // Full register set, written only once nothing is in flight
  task automatic apply_settings(input logic [15:0] wd, input logic [15:0] car_half,
                                input logic [15:0] rem_half, input logic [7:0] s_lo,
                                input logic [7:0] s_hi, input logic [9:0] offset,
                                input logic [7:0] r_speed, input logic [7:0] r_steer);
    drain_results();
    write_reg(apwc_pkg::REG_WDOG_LIMIT, wd);
    write_reg(apwc_pkg::REG_BLINK_MS_CAR, car_half);
    write_reg(apwc_pkg::REG_BLINK_MS_REMOTE, rem_half);
    write_reg(apwc_pkg::REG_STEER_MIN, {8'h00, s_lo});
    write_reg(apwc_pkg::REG_STEER_MAX, {8'h00, s_hi});
    write_reg(apwc_pkg::REG_PULSE_TRIM, {6'h00, offset});
    write_reg(apwc_pkg::REG_REMOTE_SPEED, {8'h00, r_speed});
    write_reg(apwc_pkg::REG_REMOTE_STEER, {8'h00, r_steer});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    int i;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_command  = apwc_pkg::CMD_BYTE;
    in_rx_byte  = '0;
    cfg_we      = 1'b0;
    cfg_index   = apwc_pkg::REG_WDOG_LIMIT;
    cfg_wdata   = '0;
    calm        = 1'b0;
    hold_req    = 0;
    given_typed = 1'b0;
    given_want  = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: directed table, then random traffic under a long hold-off
    for (i = 0; i < PLAN_LEN; i++) begin
      send_request(plan[i].cmd, plan[i].ch, plan[i].typed, plan[i].want);
    end
    hold_req++;
    run_traffic(300, 60);

    // Low extremes, no idling on either side
    apply_settings(16'd1, 16'd1, 16'd1, 8'd0, 8'd255, 10'd0, 8'd0, 8'd0);
    calm = 1'b1;
    run_traffic(250, 8);
    calm = 1'b0;

    // High extremes, crossed clamp bounds; sender pauses midway until drained
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd0, 10'd1000, 8'd0, 8'd255);
    run_traffic(150, 30);
    drain_results();
    hold_req++;
    run_traffic(150, 30);

    // Random settings with short timers so watchdog and blink fire often
    repeat (4) begin
      apply_settings(16'($urandom_range(1, 80)), 16'($urandom_range(1, 40)),
                     16'($urandom_range(1, 40)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 10'($urandom_range(1000)),
                     8'($urandom_range(255)), 8'($urandom_range(255)));
      run_traffic(200, 40);
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
